/* hw/rtl/tdp_pkg.sv */
`default_nettype none
package tdp_pkg;

  // field widths
  localparam int VEL_W    = 19;
  localparam int ACC_W    = 20;
  localparam int TICK_W   = 17;
  localparam int MARGIN_W = 17;
  localparam int LEN_W    = 25;
  localparam int MAG_W    = 24;
  localparam int ODO_W    = 32;
  localparam int CMD_W    = 20;
  localparam int CFG_W    = 20;
  localparam int CFG_IDX_W = 3;

  // arithmetic widths
  localparam int MUL_W    = 20;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int STEP_W   = 21;
  localparam int DIVD_W   = 2 * VEL_W;   // v*v
  localparam int DIVS_W   = ACC_W + 1;   // 2*max_acceleration
  localparam int DCNT_W   = 6;

  // register reset values
  localparam logic [VEL_W-1:0]    MAX_VEL_RST    = 19'd32768;
  localparam logic [ACC_W-1:0]    MAX_ACC_RST    = 20'd65536;
  localparam logic [TICK_W-1:0]   TICK_RST       = 17'd3277;
  localparam logic [MARGIN_W-1:0] MARGIN_RST     = 17'd3277;
  localparam logic [VEL_W-1:0]    MIN_VEL_RST    = 19'd1966;

  localparam logic [VEL_W-1:0]    VEL_MAX        = '1;
  localparam logic [MAG_W-1:0]    MAG_MAX        = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_VEL = 3'd0,
    CFG_MAX_ACC = 3'd1,
    CFG_TICK    = 3'd2,
    CFG_MARGIN  = 3'd3,
    CFG_MIN_VEL = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_TICK  = 1'b1
  } kind_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

/* hw/rtl/tdp_div.sv */
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module tdp_div
  import tdp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic              busy_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [DIVD_W-1:0] quo_r;
  logic [DIVS_W-1:0] rem_r;
  logic [DIVS_W-1:0] dsr_r;

  logic [DIVS_W:0]   rem_sh;
  logic [DIVS_W:0]   trial;
  logic              qbit;

  always_comb begin
    rem_sh = {rem_r, quo_r[DIVD_W-1]};
    trial  = rem_sh - {1'b0, dsr_r};
    qbit   = !trial[DIVS_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(DIVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIVD_W-2:0], qbit};
      rem_r <= qbit ? trial[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule
`default_nettype wire

/* hw/rtl/trapezoid_distance_profiler_top.sv */
`default_nettype none
// Trapezoidal move profiler in Q16.16. A start transfer (kind 0) latches the
// magnitude and direction of move_length and the odometer reading, clears the
// velocity and arms the move; it produces no result. Each
// tick transfer (kind 1) while a move is armed produces exactly one result:
// the signed velocity command, or a zero command with done_res set once the
// travelled distance reaches the length, which disarms the block. Ticks while
// disarmed are dropped. A tick proceeds in steps: first the transfer takes the
// odometer difference and squares the velocity, then the acceleration step is
// formed on the same shared multiplier while the divider loads v*v, then the
// bit-serial divide (38 quotient bits, then its done flag) yields the stopping
// distance v*v/(2*max_acceleration), and last the block decides braking and the
// new velocity and hands the result over. in_stall stays high for the
// whole tick. The result sits in an output register, so the next transfer
// can be taken while it waits for the consumer; the hand-off itself waits
// while the previous result is still unread. Configuration registers may
// only be written while the block is idle.
module trapezoid_distance_profiler_top
  import tdp_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // configuration
  input  wire logic                        cfg_we,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]            cfg_data,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_kind,
  input  wire logic signed [LEN_W-1:0]     in_move_length,
  input  wire logic signed [ODO_W-1:0]     in_odometer,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [CMD_W-1:0]          out_velocity_command,
  output logic                             out_done_res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_STEP,
    S_DIV,
    S_DECIDE,
    S_FINISH
  } state_t;

  state_t state_r;

  // config registers
  logic [VEL_W-1:0]    max_vel_r;
  logic [ACC_W-1:0]    max_acc_r;
  logic [TICK_W-1:0]   tick_r;
  logic [MARGIN_W-1:0] margin_r;
  logic [VEL_W-1:0]    min_vel_r;

  // move state
  logic                moving_r;
  logic                braking_r;
  logic                reverse_r;
  logic [VEL_W-1:0]    vel_r;
  logic [ODO_W-1:0]    odo_start_r;
  logic [MAG_W-1:0]    len_r;

  // tick working registers
  logic signed [ODO_W:0]   diff_r;
  logic [ODO_W:0]          dist_r;
  logic [PROD_W-1:0]       mul_r;
  logic signed [ODO_W+3:0] remain_r;
  logic                    fin_r;

  // pending result and output register
  logic [CMD_W-1:0]    res_cmd_r;
  logic                res_done_r;
  logic                out_valid_r;
  logic [CMD_W-1:0]    out_cmd_r;
  logic                out_done_r;

  logic in_xfer;
  logic out_free;

  // shared multiplier
  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_p;

  // start latch
  logic [LEN_W-1:0]  len_abs;
  logic [MAG_W-1:0]  len_mag;

  // divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  // decision
  logic [ODO_W:0]           dist_abs;
  logic signed [ODO_W+3:0]  remain_nxt;
  logic                     brake_hit;
  logic [STEP_W-1:0]        step;
  logic [VEL_W-1:0]         target;
  logic signed [VEL_W+3:0]  nv;
  logic signed [VEL_W+3:0]  nv_clamp;
  logic [VEL_W-1:0]         vel_nxt;
  logic [CMD_W-1:0]         cmd_nxt;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    if (state_r == S_IDLE) begin
      mul_a = {1'b0, vel_r};
      mul_b = {1'b0, vel_r};
    end else begin
      mul_a = max_acc_r;
      mul_b = {3'b0, tick_r};
    end
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    len_abs = in_move_length[LEN_W-1] ? (~in_move_length + 1'b1) : in_move_length;
    len_mag = len_abs[LEN_W-1] ? MAG_MAX : len_abs[MAG_W-1:0];
  end

  // divisor 2*max_acceleration, forced to 2 when acceleration is zero
  always_comb begin
    div_req.start    = (state_r == S_MUL_STEP);
    div_req.dividend = mul_r[DIVD_W-1:0];
    div_req.divisor  = (max_acc_r == '0) ? DIVS_W'(2) : {max_acc_r, 1'b0};
  end

  tdp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    dist_abs   = diff_r[ODO_W] ? (ODO_W+1)'(0) - diff_r : diff_r;
    remain_nxt = $signed({12'b0, len_r}) - $signed({3'b0, dist_r})
               - $signed({19'b0, margin_r});
    brake_hit  = $signed({{3{remain_r[ODO_W+3]}}, remain_r})
                 <= $signed({1'b0, div_rsp.quotient});
  end

  // velocity ramp toward target, floored then saturated
  always_comb begin
    step   = mul_r[STEP_W+15:16];
    target = braking_r ? '0 : max_vel_r;
    nv     = $signed({4'b0, vel_r});
    if (vel_r < target) begin
      nv = $signed({4'b0, vel_r}) + $signed({2'b0, step});
    end else if (vel_r > target) begin
      nv = $signed({4'b0, vel_r}) - $signed({2'b0, step});
    end
    nv_clamp = nv;
    if (nv_clamp < $signed({4'b0, min_vel_r})) begin
      nv_clamp = $signed({4'b0, min_vel_r});
    end
    if (nv_clamp > $signed({4'b0, VEL_MAX})) begin
      nv_clamp = $signed({4'b0, VEL_MAX});
    end
    vel_nxt = nv_clamp[VEL_W-1:0];
    cmd_nxt = reverse_r ? (CMD_W'(0) - {1'b0, vel_nxt}) : {1'b0, vel_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      max_vel_r   <= MAX_VEL_RST;
      max_acc_r   <= MAX_ACC_RST;
      tick_r      <= TICK_RST;
      margin_r    <= MARGIN_RST;
      min_vel_r   <= MIN_VEL_RST;
      moving_r    <= 1'b0;
      braking_r   <= 1'b0;
      reverse_r   <= 1'b0;
      vel_r       <= '0;
      odo_start_r <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_VEL: max_vel_r <= cfg_data[VEL_W-1:0];
          CFG_MAX_ACC: max_acc_r <= cfg_data[ACC_W-1:0];
          CFG_TICK:    tick_r    <= cfg_data[TICK_W-1:0];
          CFG_MARGIN:  margin_r  <= cfg_data[MARGIN_W-1:0];
          CFG_MIN_VEL: min_vel_r <= cfg_data[VEL_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            if (in_kind == KIND_START) begin
              len_r       <= len_mag;
              reverse_r   <= in_move_length[LEN_W-1];
              odo_start_r <= in_odometer;
              vel_r       <= '0;
              braking_r   <= 1'b0;
              moving_r    <= 1'b1;
            end else if (moving_r) begin
              diff_r  <= $signed({in_odometer[ODO_W-1], in_odometer})
                       - $signed({odo_start_r[ODO_W-1], odo_start_r});
              mul_r   <= mul_p;       // v*v
              state_r <= S_MUL_STEP;
            end
          end
        end
        S_MUL_STEP: begin
          // divider takes v*v this cycle; multiplier moves on to the step
          mul_r   <= mul_p;
          dist_r  <= dist_abs;
          state_r <= S_DIV;
        end
        S_DIV: begin
          remain_r <= remain_nxt;
          fin_r    <= (dist_r >= {9'b0, len_r});
          if (div_rsp.done) begin
            braking_r <= braking_r | brake_hit;
            state_r   <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (fin_r) begin
            res_cmd_r  <= '0;
            res_done_r <= 1'b1;
            moving_r   <= 1'b0;
            braking_r  <= 1'b0;
            vel_r      <= '0;
          end else begin
            res_cmd_r  <= cmd_nxt;
            res_done_r <= 1'b0;
            vel_r      <= vel_nxt;
          end
          state_r <= S_FINISH;
        end
        S_FINISH: begin
          // hand off once the output register is empty or being drained
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_cmd_r   <= res_cmd_r;
            out_done_r  <= res_done_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_velocity_command = out_cmd_r;
  assign out_done_res         = out_done_r;

endmodule
`default_nettype wire
